>>> hdl/rld_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rld_pkg
// Shared types and constants for the run-length decoder: symbol codes,
// emit selections and the command/status bundles between control and data.
// ----------------------------------------------------------------------------
package rld_pkg;

    // ascii digit range and count radix
    localparam logic [7:0] SYM_ZERO = 8'h30;
    localparam logic [7:0] SYM_NINE = 8'h39;
    localparam logic [3:0] RADIX    = 4'd10;

    // what the output register loads this cycle
    typedef enum logic [2:0] {
        EMIT_NONE      = 3'd0,
        EMIT_LITERAL   = 3'd1,
        EMIT_MALFORMED = 3'd2,
        EMIT_RUN_FIRST = 3'd3,
        EMIT_RUN_NEXT  = 3'd4
    } t_emit_sel;

    // controller to datapath
    typedef struct packed {
        logic      acc_digit;
        logic      clear_count;
        t_emit_sel emit_sel;
    } t_rld_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free;
        logic is_digit;
        logic eos;
        logic count_active;
        logic count_zero;
        logic count_one;
        logic remain_one;
    } t_rld_status;

endpackage

>>> hdl/rld_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rld_ctrl
// Controller: takes input bytes while idle and sequences the copies of a
// run through the datapath output register.
// ----------------------------------------------------------------------------
module rld_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  rld_pkg::t_rld_status i_status,
    output logic                 o_in_stall,
    output rld_pkg::t_rld_cmd    o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state           = r_state;
        o_in_stall        = 1'b1;
        accept            = 1'b0;
        o_cmd.acc_digit   = 1'b0;
        o_cmd.clear_count = 1'b0;
        o_cmd.emit_sel    = rld_pkg::EMIT_NONE;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = !i_status.out_free;
                accept     = i_in_valid && i_status.out_free;
                if (accept) begin
                    if (i_status.is_digit && i_status.eos) begin
                        // string ended inside a count
                        o_cmd.emit_sel    = rld_pkg::EMIT_MALFORMED;
                        o_cmd.clear_count = 1'b1;
                    end else if (i_status.is_digit) begin
                        o_cmd.acc_digit = 1'b1;
                    end else if (!i_status.count_active) begin
                        o_cmd.emit_sel = rld_pkg::EMIT_LITERAL;
                    end else if (i_status.count_zero) begin
                        // zero count swallows the byte
                        o_cmd.clear_count = 1'b1;
                    end else begin
                        o_cmd.emit_sel    = rld_pkg::EMIT_RUN_FIRST;
                        o_cmd.clear_count = 1'b1;
                        if (!i_status.count_one) begin
                            n_state = ST_RUN;
                        end
                    end
                end
            end
            ST_RUN: begin
                if (i_status.out_free) begin
                    o_cmd.emit_sel = rld_pkg::EMIT_RUN_NEXT;
                    if (i_status.remain_one) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

>>> hdl/rld_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rld_datapath
// Datapath: decimal count accumulator with saturation, run counter, held
// run symbol and the output register.
// ----------------------------------------------------------------------------
module rld_datapath #(
    parameter int MAX_RUN = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [7:0]           i_symbol,
    input  logic                 i_end_of_string,
    input  logic                 i_out_stall,
    input  rld_pkg::t_rld_cmd    i_cmd,
    output rld_pkg::t_rld_status o_status,
    output logic                 o_out_valid,
    output logic [7:0]           o_out_byte,
    output logic                 o_run_last,
    output logic                 o_malformed
);

    localparam int CW = $clog2(MAX_RUN + 1);
    localparam int AW = $clog2(MAX_RUN * 10 + 10);
    localparam logic [CW-1:0] CNT_ONE = CW'(1);
    localparam logic [AW-1:0] MAX_A   = AW'(MAX_RUN);

    logic [CW-1:0] r_count;
    logic          r_count_active;
    logic [CW-1:0] r_remain;
    logic [7:0]    r_run_sym;
    logic          r_out_valid;
    logic [7:0]    r_out_byte;
    logic          r_run_last;
    logic          r_malformed;

    logic [3:0]    digit;
    logic [AW-1:0] acc_sum;
    logic [CW-1:0] acc_next;
    logic          load;

    // classify input byte and accumulate count
    assign digit    = i_symbol[3:0] - rld_pkg::SYM_ZERO[3:0];
    assign acc_sum  = AW'(r_count) * AW'(rld_pkg::RADIX) + AW'(digit);
    assign acc_next = (acc_sum > MAX_A) ? CW'(MAX_RUN) : acc_sum[CW-1:0];
    assign load     = (i_cmd.emit_sel != rld_pkg::EMIT_NONE);

    assign o_status.out_free     = !r_out_valid || !i_out_stall;
    assign o_status.is_digit     = (i_symbol >= rld_pkg::SYM_ZERO) &&
                                   (i_symbol <= rld_pkg::SYM_NINE);
    assign o_status.eos          = i_end_of_string;
    assign o_status.count_active = r_count_active;
    assign o_status.count_zero   = (r_count == '0);
    assign o_status.count_one    = (r_count == CNT_ONE);
    assign o_status.remain_one   = (r_remain == CNT_ONE);

    // count state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count        <= '0;
            r_count_active <= 1'b0;
        end else if (i_cmd.clear_count) begin
            r_count        <= '0;
            r_count_active <= 1'b0;
        end else if (i_cmd.acc_digit) begin
            r_count        <= acc_next;
            r_count_active <= 1'b1;
        end
    end

    // run counter and held symbol
    always_ff @(posedge i_clk) begin
        case (i_cmd.emit_sel)
            rld_pkg::EMIT_RUN_FIRST: begin
                r_remain  <= r_count - CNT_ONE;
                r_run_sym <= i_symbol;
            end
            rld_pkg::EMIT_RUN_NEXT: begin
                r_remain <= r_remain - CNT_ONE;
            end
            default: begin
            end
        endcase
    end

    // output valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        case (i_cmd.emit_sel)
            rld_pkg::EMIT_LITERAL: begin
                r_out_byte  <= i_symbol;
                r_run_last  <= 1'b1;
                r_malformed <= 1'b0;
            end
            rld_pkg::EMIT_MALFORMED: begin
                r_out_byte  <= 8'h00;
                r_run_last  <= 1'b1;
                r_malformed <= 1'b1;
            end
            rld_pkg::EMIT_RUN_FIRST: begin
                r_out_byte  <= i_symbol;
                r_run_last  <= (r_count == CNT_ONE);
                r_malformed <= 1'b0;
            end
            rld_pkg::EMIT_RUN_NEXT: begin
                r_out_byte  <= r_run_sym;
                r_run_last  <= (r_remain == CNT_ONE);
                r_malformed <= 1'b0;
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_run_last  = r_run_last;
    assign o_malformed = r_malformed;

endmodule

>>> hdl/run_length_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// run_length_decoder_unit
// Run-length decoder for text with decimal prefix counts.
// ----------------------------------------------------------------------------
// Digits and plain bytes are taken at one per cycle. A byte that closes a
// count of n (1 to MAX_RUN) emits n copies, one per cycle while not stalled,
// from a single output register driven by the run counter; the input is held
// until the last copy is loaded; the last copy carries run_last. A zero count
// swallows its byte with no output. A string that ends on a digit yields one
// transfer with malformed set and out_byte zero. A literal, malformed result
// or first run copy appears the cycle after its byte is taken. A new byte is
// taken at the same edge where the waiting result leaves; while a result is
// held by i_out_stall, the input stalls, digits included.
// ----------------------------------------------------------------------------
module run_length_decoder_unit #(
    parameter int MAX_RUN = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_symbol,
    input  logic       i_end_of_string,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_run_last,
    output logic       o_malformed
);

    rld_pkg::t_rld_cmd    cmd;
    rld_pkg::t_rld_status status;

    // controller
    rld_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    // datapath
    rld_datapath #(
        .MAX_RUN (MAX_RUN)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_symbol        (i_symbol),
        .i_end_of_string (i_end_of_string),
        .i_out_stall     (i_out_stall),
        .i_cmd           (cmd),
        .o_status        (status),
        .o_out_valid     (o_out_valid),
        .o_out_byte      (o_out_byte),
        .o_run_last      (o_run_last),
        .o_malformed     (o_malformed)
    );

endmodule

>>> dv/run_length_decoder_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// run_length_decoder_unit_tb
// Self-checking bench for the decimal-prefix run-length decoder.
// ----------------------------------------------------------------------------
// Directed byte strings cover plain bytes, counted runs, zero counts,
// saturating counts and strings that end inside a count. A random stream of
// mostly well-formed count/byte sequences follows. Both handshake sides idle
// at random. Every accepted byte is decoded in the bench, and each output
// transfer is compared field by field with the oldest expected byte.
// ----------------------------------------------------------------------------
module run_length_decoder_unit_tb;

    localparam int MAX_RUN    = 64;
    localparam int IDLE_LIMIT = 1000;
    localparam int RANDOM_ITEMS = 405;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       malformed;
    } t_decoded;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    logic [7:0] i_symbol;
    logic       i_end_of_string;
    logic       o_out_valid;
    logic       i_out_stall;
    logic [7:0] o_out_byte;
    logic       o_run_last;
    logic       o_malformed;

    // decoder state mirrored in the bench
    logic [6:0] run_count;
    logic       count_open;
    t_decoded   decoded_q[$];

    int  error_count;
    int  items_sent;
    int  idle_cycles;
    bit  no_idle;

    run_length_decoder_unit #(
        .MAX_RUN(MAX_RUN)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_symbol       (i_symbol),
        .i_end_of_string(i_end_of_string),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_byte     (o_out_byte),
        .o_run_last     (o_run_last),
        .o_malformed    (o_malformed)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // idle cycles before a transfer, zero during burst stretches
    function automatic int draw_gap();
        if (no_idle) begin
            return 0;
        end
        return $urandom_range(0, 14);
    endfunction

    function automatic logic is_digit(input logic [7:0] sym);
        return (sym >= rld_pkg::SYM_ZERO) && (sym <= rld_pkg::SYM_NINE);
    endfunction

    function automatic logic [7:0] rand_non_digit();
        logic [7:0] sym;
        do begin
            sym = 8'($urandom_range(0, 255));
        end while (is_digit(sym));
        return sym;
    endfunction

    // append one expected output byte
    task automatic add_expected(input logic [7:0] out_byte, input logic run_last,
                                input logic malformed);
        t_decoded item;
        item.out_byte  = out_byte;
        item.run_last  = run_last;
        item.malformed = malformed;
        decoded_q      = {decoded_q, item};
    endtask

    // decode one accepted byte into the expected output bytes
    task automatic decode_symbol(input logic [7:0] sym, input logic eos);
        int nxt;
        int n;
        if (is_digit(sym)) begin
            if (eos) begin
                run_count  = '0;
                count_open = 1'b0;
                add_expected(8'h00, 1'b1, 1'b1);
            end else begin
                nxt = int'(run_count) * int'(rld_pkg::RADIX) +
                      int'(sym - rld_pkg::SYM_ZERO);
                if (nxt > MAX_RUN) begin
                    nxt = MAX_RUN;
                end
                run_count  = 7'(nxt);
                count_open = 1'b1;
            end
        end else if (!count_open) begin
            add_expected(sym, 1'b1, 1'b0);
        end else begin
            n = int'(run_count);
            for (int i = 0; i < n; i++) begin
                add_expected(sym, (i + 1 == n), 1'b0);
            end
            run_count  = '0;
            count_open = 1'b0;
        end
    endtask

    // one input transfer, after a random gap
    task automatic send_byte(input logic [7:0] sym, input logic eos);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid      <= 1'b1;
        i_symbol        <= sym;
        i_end_of_string <= eos;
        do @(posedge i_clk); while (o_in_stall);
        decode_symbol(sym, eos);
        items_sent++;
    endtask

    // hold the input idle until every expected byte has come out
    task automatic wait_for_drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (decoded_q.size() > 0) @(posedge i_clk);
    endtask

    // plain bytes, extremes and the neighbors of the digit range
    task automatic test_literal_bytes();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h2F, 1'b0);
        send_byte(8'h3A, 1'b1);
        wait_for_drain();
    endtask

    // counted runs, zero counts and saturation
    task automatic test_prefix_counts();
        send_byte("3", 1'b0);
        send_byte("x", 1'b0);
        send_byte("1", 1'b0);
        send_byte("y", 1'b0);
        send_byte("6", 1'b0);
        send_byte("4", 1'b0);
        send_byte("z", 1'b0);
        // zero count swallows its byte
        send_byte("0", 1'b0);
        send_byte("a", 1'b0);
        send_byte("0", 1'b0);
        send_byte("0", 1'b0);
        send_byte("a", 1'b0);
        // count above the maximum saturates
        send_byte("6", 1'b0);
        send_byte("5", 1'b0);
        send_byte("b", 1'b0);
        // run closing a string
        send_byte("2", 1'b0);
        send_byte("k", 1'b1);
        wait_for_drain();
    endtask

    // strings that end inside a count
    task automatic test_malformed_ends();
        send_byte("7", 1'b1);
        send_byte("1", 1'b0);
        send_byte("2", 1'b1);
        send_byte("q", 1'b0);
        wait_for_drain();
    endtask

    // one random sequence: mostly count plus byte, some literals and noise
    task automatic send_random_sequence();
        int kind;
        int nd;
        int pick;
        int digit;
        kind = $urandom_range(0, 99);
        if (kind < 60) begin
            pick = $urandom_range(0, 99);
            nd = (pick < 70) ? 1 : (pick < 92) ? 2 : 3;
            for (int k = 0; k < nd; k++) begin
                digit = (k == 0 && nd == 2) ? $urandom_range(0, 6) : $urandom_range(0, 9);
                send_byte(rld_pkg::SYM_ZERO + 8'(digit), 1'b0);
            end
            if (kind < 50) begin
                send_byte(rand_non_digit(), ($urandom_range(0, 7) == 0));
            end else begin
                // broken string: ends on a digit
                send_byte(rld_pkg::SYM_ZERO + 8'($urandom_range(0, 9)), 1'b1);
            end
        end else if (kind < 85) begin
            send_byte(rand_non_digit(), ($urandom_range(0, 7) == 0));
        end else begin
            send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic test_random_stream();
        int start;
        int segment;
        start   = items_sent;
        segment = 0;
        while (items_sent - start < RANDOM_ITEMS) begin
            // new stretch every ~40 items, some without any idling
            if ((items_sent - start) / 40 != segment) begin
                segment = (items_sent - start) / 40;
                no_idle = ($urandom_range(0, 3) == 0);
                if (segment == 5) begin
                    wait_for_drain();
                end
            end
            send_random_sequence();
        end
        no_idle = 1'b0;
        wait_for_drain();
    endtask

    // output side stall, drawn per result
    initial begin
        int stall_left;
        i_out_stall = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            stall_left = draw_gap();
            while (stall_left > 0) begin
                @(negedge i_clk);
                i_out_stall <= 1'b1;
                stall_left--;
            end
            @(negedge i_clk);
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_out_valid && !i_out_stall));
        end
    end

    // compare each output transfer with the oldest expected byte
    always @(posedge i_clk) begin
        t_decoded exp_item;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (decoded_q.size() == 0) begin
                $display("%0t: unexpected output transfer byte %h last %b malformed %b",
                         $realtime, o_out_byte, o_run_last, o_malformed);
                error_count++;
            end else begin
                exp_item = decoded_q.pop_front();
                if (o_out_byte !== exp_item.out_byte) begin
                    $display("%0t: out_byte expected %h actual %h",
                             $realtime, exp_item.out_byte, o_out_byte);
                    error_count++;
                end
                if (o_run_last !== exp_item.run_last) begin
                    $display("%0t: run_last expected %b actual %b",
                             $realtime, exp_item.run_last, o_run_last);
                    error_count++;
                end
                if (o_malformed !== exp_item.malformed) begin
                    $display("%0t: malformed expected %b actual %b",
                             $realtime, exp_item.malformed, o_malformed);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $realtime, IDLE_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // test sequence
    initial begin
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_symbol        = 8'h00;
        i_end_of_string = 1'b0;
        run_count       = '0;
        count_open      = 1'b0;
        error_count     = 0;
        items_sent      = 0;
        no_idle         = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_literal_bytes();
        test_prefix_counts();
        test_malformed_ends();
        test_random_stream();

        // catch any extra output after the last expected byte
        repeat (16) @(posedge i_clk);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

>>> sim.f
hdl/rld_pkg.sv
hdl/rld_ctrl.sv
hdl/rld_datapath.sv
hdl/run_length_decoder_unit.sv
dv/run_length_decoder_unit_tb.sv
